FILE: hdl/tbw_pkg.sv
// ----------------------------------------------------------------------------
// tbw_pkg - shared types and sizes for the barycentric weight pipeline
// Coordinate and weight widths, derived datapath widths, stage counts and
// the beat structs of both channels and the area struct.
// ----------------------------------------------------------------------------
package tbw_pkg;

   localparam int COORD_BITS       = 16;
   localparam int WEIGHT_FRAC_BITS = 16;
   localparam int WEIGHT_BITS      = WEIGHT_FRAC_BITS + 1;

   // edge vector components, products, cross components and areas
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int MAG_BITS  = 2 * COORD_BITS + 1;
   localparam int SQ_BITS   = 2 * MAG_BITS;
   localparam int AREA_BITS = SQ_BITS + 2;

   // divider: remainder stays below four times the full area
   localparam int REM_BITS = AREA_BITS + 2;
   localparam int QUO_BITS = 2 * WEIGHT_FRAC_BITS + 2;

   // square root: root and partial remainder
   localparam int ROOT_BITS  = WEIGHT_BITS;
   localparam int SREM_BITS  = ROOT_BITS + 2;
   localparam int TRIAL_BITS = SREM_BITS + 2;

   localparam int FRONT_STAGES = 6;
   localparam int DIV_STAGES   = QUO_BITS + 1;
   localparam int SQRT_STAGES  = ROOT_BITS;
   localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + SQRT_STAGES + 1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] px;
      logic signed [COORD_BITS-1:0] py;
      logic signed [COORD_BITS-1:0] pz;
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic signed [COORD_BITS-1:0] az;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by_coord;
      logic signed [COORD_BITS-1:0] bz;
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic signed [COORD_BITS-1:0] cz;
   } req_type;

   typedef struct packed {
      logic [WEIGHT_BITS-1:0] weight_a;
      logic [WEIGHT_BITS-1:0] weight_b;
      logic [WEIGHT_BITS-1:0] weight_c;
      logic                   degenerate;
   } rsp_type;

   // squared doubled areas: full triangle and the three sub-triangles
   typedef struct packed {
      logic [AREA_BITS-1:0] t;
      logic [AREA_BITS-1:0] sa;
      logic [AREA_BITS-1:0] sb;
      logic [AREA_BITS-1:0] sc;
   } area_type;

endpackage

FILE: hdl/tbw_front.sv
// ----------------------------------------------------------------------------
// tbw_front - squared cross-product areas
// Six stages: input, edge vectors, products, cross components (magnitude),
// squares, sums.
// ----------------------------------------------------------------------------
module tbw_front (
   input  logic              clock,
   input  logic              adv,
   input  tbw_pkg::req_type  req,
   output tbw_pkg::area_type area
);

   localparam int VEC_AB = 0;
   localparam int VEC_AC = 1;
   localparam int VEC_PA = 2;
   localparam int VEC_CP = 3;
   localparam int VEC_BP = 4;
   localparam int NUM_VEC = 5;
   localparam int NUM_CROSS = 4;

   // cross k is |u x v|^2 with u, v picked here: full, pbc, pac, pab
   localparam int U_SEL [NUM_CROSS] = '{VEC_AC, VEC_CP, VEC_AC, VEC_PA};
   localparam int V_SEL [NUM_CROSS] = '{VEC_AB, VEC_BP, VEC_PA, VEC_AB};

   tbw_pkg::req_type in_ff;

   logic signed [tbw_pkg::COORD_BITS-1:0] p [3];
   logic signed [tbw_pkg::COORD_BITS-1:0] a [3];
   logic signed [tbw_pkg::COORD_BITS-1:0] b [3];
   logic signed [tbw_pkg::COORD_BITS-1:0] c [3];

   logic signed [tbw_pkg::DIFF_BITS-1:0] diff_in [NUM_VEC][3];
   logic signed [tbw_pkg::DIFF_BITS-1:0] diff_ff [NUM_VEC][3];

   logic signed [tbw_pkg::PROD_BITS-1:0] prod_ff [NUM_CROSS][3][2];
   logic [tbw_pkg::MAG_BITS-1:0]         mag_ff  [NUM_CROSS][3];
   logic [tbw_pkg::SQ_BITS-1:0]          sq_ff   [NUM_CROSS][3];
   logic [tbw_pkg::AREA_BITS-1:0]        sum_ff  [NUM_CROSS];

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff   <= req;
         diff_ff <= diff_in;
      end
   end

   always_comb begin
      p[0] = in_ff.px;  p[1] = in_ff.py;        p[2] = in_ff.pz;
      a[0] = in_ff.ax;  a[1] = in_ff.ay;        a[2] = in_ff.az;
      b[0] = in_ff.bx;  b[1] = in_ff.by_coord;  b[2] = in_ff.bz;
      c[0] = in_ff.cx;  c[1] = in_ff.cy;        c[2] = in_ff.cz;
      for (int i = 0; i < 3; i++) begin
         diff_in[VEC_AB][i] = tbw_pkg::DIFF_BITS'(b[i]) - tbw_pkg::DIFF_BITS'(a[i]);
         diff_in[VEC_AC][i] = tbw_pkg::DIFF_BITS'(c[i]) - tbw_pkg::DIFF_BITS'(a[i]);
         diff_in[VEC_PA][i] = tbw_pkg::DIFF_BITS'(p[i]) - tbw_pkg::DIFF_BITS'(a[i]);
         diff_in[VEC_CP][i] = tbw_pkg::DIFF_BITS'(c[i]) - tbw_pkg::DIFF_BITS'(p[i]);
         diff_in[VEC_BP][i] = tbw_pkg::DIFF_BITS'(b[i]) - tbw_pkg::DIFF_BITS'(p[i]);
      end
   end

   for (genvar k = 0; k < NUM_CROSS; k++) begin : g_cross
      logic [tbw_pkg::AREA_BITS-1:0] sum_in;

      for (genvar j = 0; j < 3; j++) begin : g_comp
         localparam int M1 = (j + 1) % 3;
         localparam int M2 = (j + 2) % 3;
         logic signed [tbw_pkg::PROD_BITS-1:0] prod_hi_in;
         logic signed [tbw_pkg::PROD_BITS-1:0] prod_lo_in;
         logic signed [tbw_pkg::PROD_BITS-1:0] det;
         logic [tbw_pkg::PROD_BITS-1:0]        det_abs;
         logic [tbw_pkg::SQ_BITS-1:0]          sq_in;

         assign prod_hi_in = diff_ff[U_SEL[k]][M1] * diff_ff[V_SEL[k]][M2];
         assign prod_lo_in = diff_ff[U_SEL[k]][M2] * diff_ff[V_SEL[k]][M1];
         assign det        = prod_ff[k][j][0] - prod_ff[k][j][1];
         assign det_abs    = det[tbw_pkg::PROD_BITS-1] ? unsigned'(-det) : unsigned'(det);
         assign sq_in      = tbw_pkg::SQ_BITS'(mag_ff[k][j]) * tbw_pkg::SQ_BITS'(mag_ff[k][j]);

         always_ff @(posedge clock) begin
            if (adv) begin
               prod_ff[k][j][0] <= prod_hi_in;
               prod_ff[k][j][1] <= prod_lo_in;
               mag_ff[k][j]     <= det_abs[tbw_pkg::MAG_BITS-1:0];
               sq_ff[k][j]      <= sq_in;
            end
         end
      end

      assign sum_in = tbw_pkg::AREA_BITS'(sq_ff[k][0]) + tbw_pkg::AREA_BITS'(sq_ff[k][1])
                    + tbw_pkg::AREA_BITS'(sq_ff[k][2]);

      always_ff @(posedge clock) begin
         if (adv) begin
            sum_ff[k] <= sum_in;
         end
      end
   end

   assign area.t  = sum_ff[0];
   assign area.sa = sum_ff[1];
   assign area.sb = sum_ff[2];
   assign area.sc = sum_ff[3];

endmodule

FILE: hdl/tbw_div.sv
// ----------------------------------------------------------------------------
// tbw_div - pipelined restoring divider, one quotient bit per stage
// quo = floor(s * 4^F / t), sat flags s >= 4t.
// ----------------------------------------------------------------------------
module tbw_div (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [tbw_pkg::AREA_BITS-1:0] s,
   input  logic [tbw_pkg::AREA_BITS-1:0] t,
   output logic [tbw_pkg::QUO_BITS-1:0]  quo,
   output logic                          sat
);

   localparam int NSTEP = tbw_pkg::QUO_BITS;

   logic [tbw_pkg::REM_BITS-1:0] rem_ff [NSTEP+1];
   logic [tbw_pkg::REM_BITS-1:0] dvs_ff [NSTEP+1];
   logic [tbw_pkg::QUO_BITS-1:0] quo_ff [NSTEP+1];
   logic                         sat_ff [NSTEP+1];

   logic [tbw_pkg::REM_BITS-1:0] dvs4;

   assign dvs4 = tbw_pkg::REM_BITS'(t) << 2;

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= tbw_pkg::REM_BITS'(s);
         dvs_ff[0] <= dvs4;
         quo_ff[0] <= '0;
         sat_ff[0] <= tbw_pkg::REM_BITS'(s) >= dvs4;
      end
   end

   // shift the remainder, take off four times t where it fits
   for (genvar i = 1; i <= NSTEP; i++) begin : g_step
      logic [tbw_pkg::REM_BITS:0] trial;
      logic [tbw_pkg::REM_BITS:0] dvs_ext;
      logic                       ge;
      logic [tbw_pkg::REM_BITS:0] diff;

      assign trial   = {rem_ff[i-1], 1'b0};
      assign dvs_ext = {1'b0, dvs_ff[i-1]};
      assign ge      = trial >= dvs_ext;
      assign diff    = ge ? trial - dvs_ext : trial;

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i] <= diff[tbw_pkg::REM_BITS-1:0];
            dvs_ff[i] <= dvs_ff[i-1];
            quo_ff[i] <= {quo_ff[i-1][tbw_pkg::QUO_BITS-2:0], ge};
            sat_ff[i] <= sat_ff[i-1];
         end
      end
   end

   assign quo = quo_ff[NSTEP];
   assign sat = sat_ff[NSTEP];

endmodule

FILE: hdl/tbw_sqrt.sv
// ----------------------------------------------------------------------------
// tbw_sqrt - pipelined integer square root, one root bit per stage
// Saturated lanes leave as all ones.
// ----------------------------------------------------------------------------
module tbw_sqrt (
   input  logic                            clock,
   input  logic                            adv,
   input  logic [tbw_pkg::QUO_BITS-1:0]    quo,
   input  logic                            sat,
   output logic [tbw_pkg::WEIGHT_BITS-1:0] weight
);

   localparam int NSTEP = tbw_pkg::ROOT_BITS;

   logic [tbw_pkg::SREM_BITS-1:0] rem_ff  [NSTEP];
   logic [tbw_pkg::ROOT_BITS-1:0] root_ff [NSTEP];
   logic [tbw_pkg::QUO_BITS-1:0]  val_ff  [NSTEP];
   logic                          sat_ff  [NSTEP];

   for (genvar i = 0; i < NSTEP; i++) begin : g_step
      logic [tbw_pkg::SREM_BITS-1:0]  rem_src;
      logic [tbw_pkg::ROOT_BITS-1:0]  root_src;
      logic [tbw_pkg::QUO_BITS-1:0]   val_src;
      logic                           sat_src;
      logic [tbw_pkg::TRIAL_BITS-1:0] trial;
      logic [tbw_pkg::TRIAL_BITS-1:0] test;
      logic                           ge;
      logic [tbw_pkg::TRIAL_BITS-1:0] diff;

      if (i == 0) begin : g_head
         assign rem_src  = '0;
         assign root_src = '0;
         assign val_src  = quo;
         assign sat_src  = sat;
      end else begin : g_body
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
         assign val_src  = val_ff[i-1];
         assign sat_src  = sat_ff[i-1];
      end

      // bring down the next two bits, try (root << 2) | 1
      assign trial = {rem_src, val_src[tbw_pkg::QUO_BITS-1 -: 2]};
      assign test  = tbw_pkg::TRIAL_BITS'({root_src, 2'b01});
      assign ge    = trial >= test;
      assign diff  = ge ? trial - test : trial;

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i]  <= diff[tbw_pkg::SREM_BITS-1:0];
            root_ff[i] <= {root_src[tbw_pkg::ROOT_BITS-2:0], ge};
            val_ff[i]  <= val_src << 2;
            sat_ff[i]  <= sat_src;
         end
      end
   end

   assign weight = sat_ff[NSTEP-1] ? '1 : root_ff[NSTEP-1];

endmodule

FILE: hdl/triangle_barycentric_weights_core.sv
// ----------------------------------------------------------------------------
// triangle_barycentric_weights_core - area-ratio barycentric weights in 3D
// Pipelined datapath: cross-product areas, divider and square root per
// weight, result register.
// ----------------------------------------------------------------------------
// Takes one beat per clock: a query point and three vertices in signed Q8.8,
// and returns one beat with weights for a, b and c in unsigned Q1.16, each
// floor(sqrt(S/T) * 2^16) where T and S are the squared lengths of the full
// and sub-triangle cross products, saturating at all ones once the ratio
// reaches two. A zero-area triangle gives degenerate = 1 and zero weights.
// Throughput is one beat per cycle while the result beat is taken. The pipeline has
// six area stages, one divider set-up stage, 2F+2 restoring divider stages
// (one quotient bit each), F+1 square root stages (one root bit each) and
// the result register. The whole pipeline moves as one: a stalled result
// beat freezes every stage and raises req_stall, and nothing is lost.
// ----------------------------------------------------------------------------
module triangle_barycentric_weights_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tbw_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tbw_pkg::rsp_type rsp
);

   localparam int DEG_DEPTH = tbw_pkg::DIV_STAGES + tbw_pkg::SQRT_STAGES;

   // valid bit per stage, index 0 is the input register
   logic [tbw_pkg::LATENCY-1:0] vld_ff;
   logic [tbw_pkg::LATENCY-1:0] vld_in;
   logic                        adv;

   tbw_pkg::area_type area;

   logic [tbw_pkg::QUO_BITS-1:0]    quo_a, quo_b, quo_c;
   logic                            sat_a, sat_b, sat_c;
   logic [tbw_pkg::WEIGHT_BITS-1:0] wgt_a, wgt_b, wgt_c;

   // degenerate flag runs beside the divider and root stages
   logic             deg_ff [DEG_DEPTH];
   tbw_pkg::rsp_type rsp_ff;
   tbw_pkg::rsp_type rsp_in;

   // the pipeline advances unless the result register holds an untaken beat
   assign adv       = !(vld_ff[tbw_pkg::LATENCY-1] && rsp_stall);
   assign req_stall = !adv;
   assign vld_in    = {vld_ff[tbw_pkg::LATENCY-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   tbw_front u_front (
      .clock (clock),
      .adv   (adv),
      .req   (req),
      .area  (area)
   );

   tbw_div u_div_a (
      .clock (clock), .adv (adv), .s (area.sa), .t (area.t), .quo (quo_a), .sat (sat_a)
   );
   tbw_div u_div_b (
      .clock (clock), .adv (adv), .s (area.sb), .t (area.t), .quo (quo_b), .sat (sat_b)
   );
   tbw_div u_div_c (
      .clock (clock), .adv (adv), .s (area.sc), .t (area.t), .quo (quo_c), .sat (sat_c)
   );

   tbw_sqrt u_sqrt_a (
      .clock (clock), .adv (adv), .quo (quo_a), .sat (sat_a), .weight (wgt_a)
   );
   tbw_sqrt u_sqrt_b (
      .clock (clock), .adv (adv), .quo (quo_b), .sat (sat_b), .weight (wgt_b)
   );
   tbw_sqrt u_sqrt_c (
      .clock (clock), .adv (adv), .quo (quo_c), .sat (sat_c), .weight (wgt_c)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         deg_ff[0] <= area.t == '0;
         for (int i = 1; i < DEG_DEPTH; i++) begin
            deg_ff[i] <= deg_ff[i-1];
         end
      end
   end

   // zero area: divider output is meaningless, force weights to zero
   always_comb begin
      rsp_in.degenerate = deg_ff[DEG_DEPTH-1];
      rsp_in.weight_a   = deg_ff[DEG_DEPTH-1] ? '0 : wgt_a;
      rsp_in.weight_b   = deg_ff[DEG_DEPTH-1] ? '0 : wgt_b;
      rsp_in.weight_c   = deg_ff[DEG_DEPTH-1] ? '0 : wgt_c;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[tbw_pkg::LATENCY-1];
   assign rsp       = rsp_ff;

   // a waiting result beat holds back intake
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("intake open while result beat is stalled");

   // an empty result register never blocks intake
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("intake stalled with no result pending");

   // degenerate beats carry zero weights
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.degenerate) |->
         (rsp.weight_a == '0 && rsp.weight_b == '0 && rsp.weight_c == '0))
      else $error("degenerate beat with nonzero weight");

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the barycentric weight pipeline
// Queue-fed driver and clocked monitor. Each accepted beat is predicted from
// exact wide-integer areas and checked field by field against the result.
// ----------------------------------------------------------------------------
module tb;

   localparam int WDOG_LIMIT = 4000;
   localparam int HOLDOFF    = 200;
   localparam logic [tbw_pkg::WEIGHT_BITS-1:0] W_TOP = '1;

   typedef struct {
      tbw_pkg::req_type r;
      bit               drain_first;   // sender waits for every result before this beat
   } pend_item_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   tbw_pkg::req_type req = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   tbw_pkg::rsp_type rsp;

   pend_item_type    pend_q[$];
   tbw_pkg::rsp_type weights_due[$];
   int               n_sent = 0;
   int               n_got = 0;
   int               n_err = 0;
   int               wdog = 0;
   int               hold_cnt = 0;
   bit               hold_done = 0;

   triangle_barycentric_weights_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req(req),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   // squared length of u x v, exact; components are at most 17-bit signed
   function automatic logic [159:0] cross_sq(longint u[3], longint v[3]);
      longint x, y, z;
      logic [159:0] xs, ys, zs;
      x  = u[1] * v[2] - u[2] * v[1];
      y  = u[2] * v[0] - u[0] * v[2];
      z  = u[0] * v[1] - u[1] * v[0];
      xs = (x < 0) ? -x : x;
      ys = (y < 0) ? -y : y;
      zs = (z < 0) ? -z : z;
      return xs * xs + ys * ys + zs * zs;
   endfunction

   // floor(sqrt(s/t) * 2^F), saturating; t non-zero
   function automatic logic [tbw_pkg::WEIGHT_BITS-1:0] area_ratio(logic [159:0] s,
                                                                  logic [159:0] t);
      logic [239:0] num;
      logic [63:0]  q, res, trial;
      if (s >= (t << 2)) return W_TOP;
      num = s;
      num = num << (2 * tbw_pkg::WEIGHT_FRAC_BITS);
      q   = 64'(num / t);
      res = 0;
      // quotient is below 4^(F+1), so the root fits in F+1 bits
      for (int b = tbw_pkg::WEIGHT_BITS - 1; b >= 0; b--) begin
         trial = res | (64'd1 << b);
         if (trial * trial <= q) res = trial;
      end
      return (res > W_TOP) ? W_TOP : res[tbw_pkg::WEIGHT_BITS-1:0];
   endfunction

   function automatic tbw_pkg::rsp_type weights_of(tbw_pkg::req_type r);
      longint p[3], a[3], b[3], c[3];
      longint ab[3], ac[3], pa[3], cp[3], bp[3];
      logic [159:0] t, sa, sb, sc;
      tbw_pkg::rsp_type w;
      p = '{r.px, r.py, r.pz};
      a = '{r.ax, r.ay, r.az};
      b = '{r.bx, r.by_coord, r.bz};
      c = '{r.cx, r.cy, r.cz};
      for (int i = 0; i < 3; i++) begin
         ab[i] = b[i] - a[i];
         ac[i] = c[i] - a[i];
         pa[i] = p[i] - a[i];
         cp[i] = c[i] - p[i];
         bp[i] = b[i] - p[i];
      end
      t  = cross_sq(ac, ab);
      sa = cross_sq(cp, bp);
      sb = cross_sq(ac, pa);
      sc = cross_sq(pa, ab);
      w = '0;
      if (t == 0) begin
         w.degenerate = 1'b1;
      end else begin
         w.weight_a = area_ratio(sa, t);
         w.weight_b = area_ratio(sb, t);
         w.weight_c = area_ratio(sc, t);
      end
      return w;
   endfunction

   // ------------------------------------------------------------------ driver
   // no idling while beats 400..600 go out
   always @(posedge clock) begin
      bit nxt_valid;
      nxt_valid = req_valid;
      if (reset) begin
         nxt_valid = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            weights_due.push_back(weights_of(req));
            n_sent++;
         end
         if (!req_valid || !req_stall) begin
            nxt_valid = 1'b0;
            if (pend_q.size() > 0 &&
                !(pend_q[0].drain_first && weights_due.size() != 0) &&
                ((n_sent >= 400 && n_sent < 600) || $urandom_range(99) >= 36)) begin
               req       <= pend_q[0].r;
               nxt_valid = 1'b1;
               pend_q.pop_front();
            end
         end
      end
      req_valid <= nxt_valid;
   end

   // ----------------------------------------------------------------- monitor
   always @(posedge clock) begin
      tbw_pkg::rsp_type e;
      bit nxt_stall;
      nxt_stall = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            n_got++;
            if (weights_due.size() == 0) begin
               n_err++;
               if (n_err <= 10) $display("unexpected result beat %h", rsp);
            end else begin
               e = weights_due.pop_front();
               if (rsp.weight_a !== e.weight_a || rsp.weight_b !== e.weight_b ||
                   rsp.weight_c !== e.weight_c || rsp.degenerate !== e.degenerate) begin
                  n_err++;
                  if (n_err <= 10)
                     $display("mismatch beat %0d: exp a=%h b=%h c=%h d=%b got a=%h b=%h c=%h d=%b",
                              n_got, e.weight_a, e.weight_b, e.weight_c, e.degenerate,
                              rsp.weight_a, rsp.weight_b, rsp.weight_c, rsp.degenerate);
               end
            end
         end
         // long hold-off once, so the pipe fills and pushes back on the sender
         if (hold_cnt > 0) begin
            hold_cnt--;
            nxt_stall = 1'b1;
         end else if (!hold_done && n_got == 300) begin
            hold_done = 1;
            hold_cnt  = HOLDOFF;
            nxt_stall = 1'b1;
         end else if (!(n_got >= 500 && n_got < 700)) begin
            nxt_stall = ($urandom_range(99) < 36);
         end
      end
      rsp_stall <= nxt_stall;
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // --------------------------------------------------------------- stimulus
   function automatic logic signed [15:0] rnd_coord();
      return 16'($urandom);
   endfunction

   function automatic logic signed [15:0] near_coord();
      return 16'($urandom_range(2047) - 1024);
   endfunction

   task automatic add_item(tbw_pkg::req_type r, bit drain);
      pend_item_type it;
      it.r = r;
      it.drain_first = drain;
      pend_q.push_back(it);
   endtask

   task automatic add_pts(int p0, int p1, int p2, int a0, int a1, int a2,
                          int b0, int b1, int b2, int c0, int c1, int c2);
      tbw_pkg::req_type r;
      r = '{16'(p0), 16'(p1), 16'(p2), 16'(a0), 16'(a1), 16'(a2),
            16'(b0), 16'(b1), 16'(b2), 16'(c0), 16'(c1), 16'(c2)};
      add_item(r, 0);
   endtask

   initial begin
      tbw_pkg::req_type r;
      int k, sel;
      // directed: zero triangle, unit triangle with point at each vertex,
      // centroid-ish, far point (saturation), collinear and full-scale extremes
      add_pts(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_pts(0, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
      add_pts(256, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
      add_pts(0, 256, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
      add_pts(85, 85, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
      add_pts(128, 128, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
      add_pts(30000, -30000, 500, 0, 0, 0, 256, 0, 0, 0, 256, 0);
      add_pts(10, 10, 10000, 0, 0, 0, 256, 0, 0, 0, 0, 256);
      add_pts(5, 6, 7, 0, 0, 0, 100, 100, 100, 300, 300, 300);
      add_pts(5, 6, 7, 1, 2, 3, 1, 2, 3, 9, 9, 9);
      add_pts(-32768, -32768, -32768, 32767, 32767, 32767,
              -32768, 32767, -32768, 32767, -32768, -32768);
      add_pts(32767, 32767, 32767, -32768, -32768, -32768,
              32767, -32768, 32767, -32768, 32767, 32767);
      add_pts(-32768, 32767, 0, -32768, -32768, -32768,
              32767, -32768, -32768, -32768, 32767, -32768);
      add_pts(32767, -32768, 32767, -32768, -32768, -32768,
              32767, 32767, 32767, -32768, 32767, 32767);
      add_pts(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
      add_pts(0, 0, 0, -32768, 0, 0, 32767, 0, 0, 0, 32767, 0);
      add_pts(-256, 256, 0, 256, -256, 128, -128, 64, 32, 16, 8, -4);
      add_pts(1, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0);

      // random: full-range, nearby triangles, and degenerate cases
      for (k = 0; k < 1450; k++) begin
         sel = $urandom_range(9);
         if (sel < 4) begin
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         end else if (sel < 8) begin
            r = '{near_coord(), near_coord(), near_coord(), near_coord(),
                  near_coord(), near_coord(), near_coord(), near_coord(),
                  near_coord(), near_coord(), near_coord(), near_coord()};
            if (sel == 7) r.pz = r.az;
         end else if (sel == 8) begin
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            r.cx = r.ax; r.cy = r.ay; r.cz = r.az;
         end else begin
            r = '{rnd_coord(), rnd_coord(), rnd_coord(), near_coord(),
                  near_coord(), near_coord(), 16'sd0, 16'sd0, 16'sd0,
                  16'sd0, 16'sd0, 16'sd0};
            r.bx = 16'(r.ax + 3); r.by_coord = 16'(r.ay - 2); r.bz = 16'(r.az + 1);
            r.cx = 16'(r.ax - 6); r.cy = 16'(r.ay + 4); r.cz = 16'(r.az - 2);
         end
         add_item(r, k == 900);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      wait (pend_q.size() == 0 && !req_valid && weights_due.size() == 0);
      repeat (tbw_pkg::LATENCY + 20) @(posedge clock);
      if (n_err == 0 && weights_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
